// File: design/sigact_pkg.sv
// Shared types, command codes and the sigmoid breakpoint table.
package sigact_pkg;

    localparam int SEG_BITS = 5;
    localparam int SEGMENTS = 1 << SEG_BITS;
    localparam int IDX_W    = SEG_BITS + 1;

    // 1.0 in Q0.15
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    typedef enum logic [1:0] {
        CMD_FWD  = 2'd0,
        CMD_BWD  = 2'd1,
        CMD_BWD2 = 2'd2,
        CMD_RFWD = 2'd3
    } t_cmd;

    // Per-stage load enables shared by the datapath blocks.
    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } t_pipe_en;

    // sigmoid(x_k) in Q0.15 at x_k = -8 + 16k/SEGMENTS, k = 0..SEGMENTS
    localparam logic [14:0] SIG_TABLE [SEGMENTS+1] = '{
        15'd11,    15'd18,    15'd30,    15'd49,    15'd81,    15'd133,
        15'd219,   15'd360,   15'd589,   15'd961,   15'd1554,  15'd2486,
        15'd3906,  15'd5978,  15'd8813,  15'd12371, 15'd16384, 15'd20397,
        15'd23955, 15'd26790, 15'd28862, 15'd30282, 15'd31214, 15'd31807,
        15'd32179, 15'd32408, 15'd32549, 15'd32635, 15'd32687, 15'd32719,
        15'd32738, 15'd32750, 15'd32757
    };

endpackage

// File: design/sigact_interp.sv
// Forward path: table lookup and linear interpolation over three stages.
module sigact_interp import sigact_pkg::*; (
    input  logic               i_clk,
    input  t_pipe_en           i_en,
    input  logic signed [15:0] i_x,
    output logic        [14:0] o_y
);

    logic [15:0]      u;
    logic [IDX_W-1:0] idx_lo;
    logic [IDX_W-1:0] idx_hi;
    logic [15:0]      frac;
    logic [14:0]      lo;
    logic [14:0]      hi;
    logic [15:0]      y_sum;

    logic [14:0] r_lo_a, r_diff_a, r_lo_b, r_y;
    logic [15:0] r_frac_a;
    logic [30:0] r_prod_b;

    // offset binary: u = x + 32768
    assign u      = {~i_x[15], i_x[14:0]};
    assign idx_lo = {1'b0, u[15 -: SEG_BITS]};
    assign idx_hi = idx_lo + IDX_W'(1);
    assign frac   = {u[15-SEG_BITS:0], {SEG_BITS{1'b0}}};
    assign lo     = SIG_TABLE[idx_lo];
    assign hi     = SIG_TABLE[idx_hi];

    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_lo_a   <= lo;
            r_diff_a <= (hi >= lo) ? (hi - lo) : 15'd0;
            r_frac_a <= frac;
        end
        if (i_en.b) begin
            r_lo_b   <= r_lo_a;
            r_prod_b <= {16'd0, r_diff_a} * {15'd0, r_frac_a};
        end
        if (i_en.c) begin
            r_y <= y_sum[14:0];
        end
    end

    // round the interpolation step half up
    assign y_sum = {1'b0, r_lo_b} + {1'b0, r_prod_b[30:16]} + {15'd0, r_prod_b[15]};
    assign o_y   = r_y;

endmodule

// File: design/sigact_deriv.sv
// Derivative path: y*(1-y), its rounded square, and the product with g.
module sigact_deriv import sigact_pkg::*; (
    input  logic               i_clk,
    input  t_pipe_en           i_en,
    input  logic        [14:0] i_y,
    input  logic signed [15:0] i_g,
    input  logic               i_second,
    output logic signed [45:0] o_prod
);

    logic        [15:0] comp_y;
    logic        [30:0] d_full;
    logic        [27:0] d2;
    logic        [28:0] mult_sel;
    logic signed [29:0] mult_s;
    logic signed [45:0] prod;

    logic        [28:0] r_d_a, r_d_b;
    logic signed [15:0] r_g_a, r_g_b;
    logic               r_sec_a, r_sec_b;
    logic        [57:0] r_dd_b;
    logic signed [45:0] r_prod_c;

    assign comp_y = ONE_Q15 - {1'b0, i_y};
    assign d_full = {16'd0, i_y} * {15'd0, comp_y};

    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_d_a   <= d_full[28:0];
            r_g_a   <= i_g;
            r_sec_a <= i_second;
        end
        if (i_en.b) begin
            r_dd_b  <= r_d_a * r_d_a;
            r_d_b   <= r_d_a;
            r_g_b   <= r_g_a;
            r_sec_b <= r_sec_a;
        end
        if (i_en.c) begin
            r_prod_c <= prod;
        end
    end

    // bring d*d back to Q0.30, ties up
    assign d2       = r_dd_b[57:30] + {27'd0, r_dd_b[29]};
    assign mult_sel = r_sec_b ? {1'b0, d2} : r_d_b;
    assign mult_s   = {1'b0, mult_sel};
    assign prod     = r_g_b * mult_s;
    assign o_prod   = r_prod_c;

endmodule

// File: design/sigmoid_activation_fwd_bwd_unit.sv
// Top level of the sigmoid forward/backward unit with stream handshakes.
// Throughput: one item per cycle while i_m_axis_tready holds; four register stages,
// each at most one multiplier deep, lie between an input transfer and its result
// (lookup and y*(1-y), products, final product, sum and clip).
// Reset (i_rst_n low, synchronous) clears only the stage valid bits; data holds.
// Each stage advances when it is empty or the stage after it advances.
module sigmoid_activation_fwd_bwd_unit import sigact_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata, low bit up: pre_activation[15:0], activation[30:16],
    // upstream_value[46:31], accumulator[62:47], zero pad[63]
    input  logic [63:0] i_s_axis_tdata,
    // tuser: command[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: result[15:0]
    output logic [15:0] o_m_axis_tdata,
    // tuser: saturated[0]
    output logic        o_m_axis_tuser
);

    // stage valid bits and ready chain
    logic     r_va, r_vb, r_vc, r_vd;
    logic     rdy_a, rdy_b, rdy_c, rdy_d;
    t_pipe_en en;

    // control and accumulator carried alongside the datapath
    t_cmd               in_cmd;
    t_cmd               r_cmd_a, r_cmd_b, r_cmd_c;
    logic signed [15:0] r_acc_a, r_acc_b, r_acc_c;

    logic        [14:0] fwd_y;
    logic signed [45:0] deriv_prod;

    // final stage
    logic signed [15:0] rnd_hi;
    logic signed [15:0] rnd_val;
    logic signed [17:0] acc_sum;
    logic        [15:0] n_result;
    logic               n_sat;
    logic        [15:0] r_result;
    logic               r_sat;

    assign rdy_d = !r_vd || i_m_axis_tready;
    assign rdy_c = !r_vc || rdy_d;
    assign rdy_b = !r_vb || rdy_c;
    assign rdy_a = !r_va || rdy_b;

    assign en.a = rdy_a;
    assign en.b = rdy_b;
    assign en.c = rdy_c;

    assign o_s_axis_tready = rdy_a;
    assign in_cmd          = t_cmd'(i_s_axis_tuser);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_s_axis_tvalid;
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
            if (rdy_d) r_vd <= r_vc;
        end
    end

    // advance command and accumulator with their stage
    always_ff @(posedge i_clk) begin
        if (en.a) begin
            r_cmd_a <= in_cmd;
            r_acc_a <= i_s_axis_tdata[62:47];
        end
        if (en.b) begin
            r_cmd_b <= r_cmd_a;
            r_acc_b <= r_acc_a;
        end
        if (en.c) begin
            r_cmd_c <= r_cmd_b;
            r_acc_c <= r_acc_b;
        end
    end

    sigact_interp u_interp (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (i_s_axis_tdata[15:0]),
        .o_y   (fwd_y)
    );

    sigact_deriv u_deriv (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_y      (i_s_axis_tdata[30:16]),
        .i_g      (i_s_axis_tdata[46:31]),
        .i_second (in_cmd == CMD_BWD2),
        .o_prod   (deriv_prod)
    );

    // product back to Q4.12: shift right by 30, ties toward plus infinity
    assign rnd_hi  = deriv_prod[45:30];
    assign rnd_val = rnd_hi + {15'd0, deriv_prod[29]};
    assign acc_sum = 18'(r_acc_c) + 18'(rnd_val);

    always_comb begin
        n_result = 16'd0;
        n_sat    = 1'b0;
        unique case (r_cmd_c)
            CMD_FWD: begin
                n_result = {1'b0, fwd_y};
            end
            CMD_RFWD: begin
                n_result = rnd_val;
            end
            CMD_BWD, CMD_BWD2: begin
                if (acc_sum > 18'sd32767) begin
                    n_result = 16'h7fff;
                    n_sat    = 1'b1;
                end else if (acc_sum < -18'sd32768) begin
                    n_result = 16'h8000;
                    n_sat    = 1'b1;
                end else begin
                    n_result = acc_sum[15:0];
                end
            end
            default: begin
                n_result = 16'd0;
                n_sat    = 1'b0;
            end
        endcase
    end

    // output register: hold while the master side stalls
    always_ff @(posedge i_clk) begin
        if (rdy_d) begin
            r_result <= n_result;
            r_sat    <= n_sat;
        end
    end

    assign o_m_axis_tvalid = r_vd;
    assign o_m_axis_tdata  = r_result;
    assign o_m_axis_tuser  = r_sat;

    // an accepted transfer always occupies the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_va)
        else $error("accepted item missing from first stage");

    // a stalled last datapath stage keeps its item
    a_stage_c_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc && !rdy_d |=> r_vc && $stable(r_cmd_c) && $stable(r_acc_c))
        else $error("stage C item lost under stall");

    // a clipped result sits exactly at a range limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            (r_result == 16'h7fff || r_result == 16'h8000))
        else $error("saturated flag without clipped value");

endmodule
